>>> design/tcw_pkg.sv
package tcw_pkg;

	localparam int DEF_ROWS    = 25;
	localparam int DEF_COLUMNS = 80;

	// Cursor widths cover the largest supported screen (32 rows, 128 columns)
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;

	localparam logic [7:0] CHAR_SPACE     = 8'd32;
	localparam logic [7:0] CHAR_LAST      = 8'd126;
	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] COLOR_RESET    = 8'd7;
	localparam logic [15:0] CELL_BLANK    = 16'h0720;

	typedef enum logic [1:0] {
		OP_PUT_CUR = 2'd0,
		OP_PUT_POS = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_CHAR  = 2'd2
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [7:0] cell_color;
		logic [7:0] col;
		logic [7:0] row;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [15:0] cell_data;
	} result_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             scroll;
	} cur_step_t;

	function automatic logic is_printable(input logic [7:0] c);
		return (c >= CHAR_SPACE) && (c <= CHAR_LAST);
	endfunction

endpackage

>>> design/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/tcw_cursor.sv
module tcw_cursor
	import tcw_pkg::*;
#(
	parameter int ROWS    = DEF_ROWS,
	parameter int COLUMNS = DEF_COLUMNS
) (
	input  logic [ROW_W-1:0] cur_row,
	input  logic [COL_W-1:0] cur_col,
	input  logic             newline,
	output cur_step_t        step
);

	logic row_adv;
	logic last_row;

	assign last_row = (cur_row == ROW_W'(ROWS - 1));
	assign row_adv  = newline || (cur_col == COL_W'(COLUMNS - 1));

	always_comb begin
		step.col    = row_adv ? '0 : cur_col + COL_W'(1);
		step.scroll = row_adv && last_row;
		// stay on the last row when scrolling
		if (row_adv && !last_row) begin
			step.row = cur_row + ROW_W'(1);
		end else begin
			step.row = cur_row;
		end
	end

endmodule

>>> design/text_console_writer_core.sv
// Results: put (unless it scrolls), write and out-of-range read report in the cycle after the
// transfer; an in-range read after state S_READ. Scroll and clear walk the cells through the one
// write port of the cell memory, one cell a cycle; the fill after a scroll holds while the last
// copy drains. In-range read, scroll, clear and the reset pass keep busy high, blocking start.
// Reset: the cell memory is zeroed by a pass over every cell with busy high; cursor 0,
// text colour 7. Results cannot be stalled by the receiver.
module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int ROWS    = DEF_ROWS,
	parameter int COLUMNS = DEF_COLUMNS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LAST = AW'(COLUMNS * (ROWS - 1) - 1);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_READ   = 6'b000100,
		S_SCROLL = 6'b001000,
		S_FILL   = 6'b010000,
		S_CLEAR  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    walk_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;
	logic [7:0]       text_color_q;
	logic             done_q;
	result_t          res_q;
	logic             copy_s1;
	logic [AW-1:0]    copy_addr_s1;

	logic             accept;
	logic             in_range;
	logic             newline;
	cur_step_t        step;
	logic [ROW_W-1:0] acc_row;
	logic [COL_W-1:0] acc_col;
	logic [AW-1:0]    acc_addr;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [CELL_W-1:0] wdata;
	logic             re;
	logic [AW-1:0]    raddr;
	logic [CELL_W-1:0] rdata;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign done    = done_q;
	assign result  = res_q;
	assign newline = (cmd.ch == CHAR_NEWLINE);
	assign in_range = (cmd.col < 8'(COLUMNS)) && (cmd.row < 8'(ROWS));

	tcw_cursor #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_cursor (
		.cur_row (cur_row_q),
		.cur_col (cur_col_q),
		.newline (newline),
		.step    (step)
	);

	// One multiplier serves the cursor and the explicit position
	always_comb begin
		if (cmd.op == OP_PUT_CUR) begin
			acc_row = cur_row_q;
			acc_col = cur_col_q;
		end else begin
			acc_row = cmd.row[ROW_W-1:0];
			acc_col = cmd.col[COL_W-1:0];
		end
	end

	assign acc_addr = AW'(acc_row) * AW'(COLUMNS) + AW'(acc_col);

	// Write port: a pending scroll copy wins over everything else
	always_comb begin
		we    = 1'b0;
		waddr = walk_q;
		wdata = '0;
		priority if (copy_s1) begin
			we    = 1'b1;
			waddr = copy_addr_s1;
			wdata = rdata;
		end else if (state_q == S_INIT) begin
			we = 1'b1;
		end else if (state_q == S_CLEAR) begin
			we    = 1'b1;
			wdata = CELL_BLANK;
		end else if (state_q == S_FILL) begin
			we    = 1'b1;
			wdata = {text_color_q, CHAR_SPACE};
		end else if (accept && cmd.op == OP_PUT_CUR) begin
			we    = !newline && is_printable(cmd.ch);
			waddr = acc_addr;
			wdata = {text_color_q, cmd.ch};
		end else if (accept && cmd.op == OP_PUT_POS) begin
			we    = in_range && is_printable(cmd.ch);
			waddr = acc_addr;
			wdata = {cmd.cell_color, cmd.ch};
		end else begin
			we = 1'b0;
		end
	end

	always_comb begin
		if (state_q == S_SCROLL) begin
			re    = 1'b1;
			raddr = walk_q + AW'(COLUMNS);
		end else begin
			re    = accept && (cmd.op == OP_READ) && in_range;
			raddr = acc_addr;
		end
	end

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= COLOR_RESET;
		end else if (cfg_we) begin
			text_color_q <= cfg_wdata;
		end
	end

	// Copy pipeline: read one row down, write back in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_s1 <= 1'b0;
		end else begin
			copy_s1 <= (state_q == S_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= walk_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			walk_q    <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					walk_q <= walk_q + AW'(1);
					if (walk_q == LAST_ADDR) begin
						walk_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.op)
							OP_PUT_CUR: begin
								cur_row_q <= step.row;
								cur_col_q <= step.col;
								if (step.scroll) begin
									walk_q  <= '0;
									state_q <= S_SCROLL;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_PUT_POS: begin
								done_q <= 1'b1;
							end
							OP_CLEAR: begin
								walk_q  <= '0;
								state_q <= S_CLEAR;
							end
							OP_READ: begin
								if (in_range) begin
									state_q <= S_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCROLL: begin
					walk_q <= walk_q + AW'(1);
					if (walk_q == COPY_LAST) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					// hold while the last copy drains through the write port
					if (!copy_s1) begin
						walk_q <= walk_q + AW'(1);
						if (walk_q == LAST_ADDR) begin
							walk_q  <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_CLEAR: begin
					walk_q <= walk_q + AW'(1);
					if (walk_q == LAST_ADDR) begin
						walk_q  <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
					walk_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.cell_data <= '0;
			unique case (cmd.op)
				OP_PUT_CUR: begin
					res_q.status     <= (newline || is_printable(cmd.ch)) ? ST_OK : ST_CHAR;
					res_q.cursor_row <= 7'(step.row);
					res_q.cursor_col <= 7'(step.col);
				end
				OP_PUT_POS: begin
					if (!in_range) begin
						res_q.status <= ST_RANGE;
					end else if (!is_printable(cmd.ch)) begin
						res_q.status <= ST_CHAR;
					end else begin
						res_q.status <= ST_OK;
					end
					res_q.cursor_row <= 7'(cur_row_q);
					res_q.cursor_col <= 7'(cur_col_q);
				end
				OP_READ: begin
					res_q.status     <= in_range ? ST_OK : ST_RANGE;
					res_q.cursor_row <= 7'(cur_row_q);
					res_q.cursor_col <= 7'(cur_col_q);
				end
				default: begin
					res_q.status     <= ST_OK;
					res_q.cursor_row <= 7'(cur_row_q);
					res_q.cursor_col <= 7'(cur_col_q);
				end
			endcase
		end else if (state_q == S_READ) begin
			res_q.cell_data <= rdata;
		end
	end

endmodule

>>> design/tcw_checker.sv
module tcw_checker
	import tcw_pkg::*;
#(
	parameter int ROWS    = DEF_ROWS,
	parameter int COLUMNS = DEF_COLUMNS
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input cmd_t    cmd,
	input logic    done,
	input result_t result
);

	logic accept;
	assign accept = start && !busy;

	// an explicit write always reports on the next cycle
	a_put_pos_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == OP_PUT_POS |=> done)
		else $error("explicit write did not report next cycle");

	a_read_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == OP_READ |=> busy || done)
		else $error("read neither pending nor reported");

	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.cursor_row < 7'(ROWS)) && (result.cursor_col < 7'(COLUMNS)))
		else $error("cursor outside the screen");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.cell_data == '0)
		else $error("failed command returned cell data");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result transfer while still busy");

endmodule

bind text_console_writer_core tcw_checker #(
	.ROWS    (ROWS),
	.COLUMNS (COLUMNS)
) u_tcw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);
